/* sv/sorted_tag_merge_filter_core_assert.svh */
// Assertion macros shared by the tag merge filter RTL.
`ifndef SORTED_TAG_MERGE_FILTER_CORE_ASSERT_SVH
`define SORTED_TAG_MERGE_FILTER_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define STMF_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("stmf assertion failed");

// Next-cycle implication, checked outside reset.
`define STMF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("stmf assertion failed");

`endif

/* sv/stmf_pkg.sv */
// Package with types, codes and defaults of the sorted tag merge filter.
`timescale 1ns / 1ps
package stmf_pkg;

    // Default sizes.
    localparam int unsigned MAX_TAGS_DEFAULT   = 1024;
    localparam int unsigned MAX_FRAMES_DEFAULT = 4096;

    // Field widths.
    localparam int unsigned TAG_COUNT_W   = 11;
    localparam int unsigned NUM_FRAMES_W  = 13;
    localparam int unsigned FRAME_INDEX_W = 12;
    localparam int unsigned DEST_SLOT_W   = 22;
    localparam int unsigned TAG_INDEX_W   = 10;
    localparam int unsigned MATCH_CNT_W   = 11;
    localparam int unsigned KEY_W         = 32;
    localparam int unsigned PAYLOAD_W     = 64;

    // Item mode codes.
    localparam logic [1:0] MODE_LOAD   = 2'd0;
    localparam logic [1:0] MODE_START  = 2'd1;
    localparam logic [1:0] MODE_RECORD = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] REG_TAG_COUNT   = 2'd0;
    localparam logic [1:0] REG_NUM_FRAMES  = 2'd1;
    localparam logic [1:0] REG_FRAME_INDEX = 2'd2;
    localparam logic [1:0] REG_OUTPUT_MODE = 2'd3;

    // APB address width.
    localparam int unsigned CFG_ADDR_W = 4;

    // Input word.
    typedef struct packed {
        logic [1:0]                  mode;
        logic [TAG_INDEX_W-1:0]      tag_address;
        logic signed [KEY_W-1:0]     key;
        logic [PAYLOAD_W-1:0]        payload;
    } t_in_word;

    // Result word.
    typedef struct packed {
        logic [DEST_SLOT_W-1:0]      dest_slot;
        logic [TAG_INDEX_W-1:0]      tag_index;
        logic [PAYLOAD_W-1:0]        record_out;
        logic [MATCH_CNT_W-1:0]      match_count;
        logic                        final_tag;
    } t_out_word;

endpackage

/* sv/stmf_ram.sv */
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module stmf_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

/* sv/sorted_tag_merge_filter_core.sv */
// Sorted tag merge filter: tag table, scan sequencer and result register.
//
// Use: items enter on i_item when start is high and busy is low. A load word
// writes one entry of the ascending tag table, a start word opens a frame,
// and a record word is merged against the table. Load and start words give
// no result. A record word scans the table with one compare per cycle
// against the tag read from the table RAM, stepping the pointer over lower
// tags; a hit goes on to the slot multiply, while a miss or a scan that runs
// off the end of the table returns to idle. Over a sorted stream the pointer
// steps over at most the table size per frame.
// A hit raises o_strobe for exactly one cycle, in the cycle after the slot
// multiply. The receiver cannot stall; a later hit overwrites o_result.
// Registers tag_count, num_frames, frame_index and output_mode sit on the
// APB port at byte addresses 0, 4, 8 and 12 and are to be written while
// idle; the block itself does not enforce this.
// Reset clears the pointer, frame state, strobe and registers; the tag
// table holds no defined value until loaded.
`timescale 1ns / 1ps
module sorted_tag_merge_filter_core #(
    parameter int unsigned MAX_TAGS   = stmf_pkg::MAX_TAGS_DEFAULT,
    parameter int unsigned MAX_FRAMES = stmf_pkg::MAX_FRAMES_DEFAULT
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  stmf_pkg::t_in_word            i_item,
    output logic                          o_strobe,
    output stmf_pkg::t_out_word           o_result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [stmf_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    import stmf_pkg::*;

    `include "sorted_tag_merge_filter_core_assert.svh"

    // Widths derived from the table and frame limits.
    localparam int unsigned AW  = $clog2(MAX_TAGS);
    localparam int unsigned PW  = $clog2(MAX_TAGS + 1);
    localparam int unsigned CW  = (PW > TAG_COUNT_W) ? PW : TAG_COUNT_W;
    localparam int unsigned FW  = $clog2(MAX_FRAMES + 1);
    localparam int unsigned EFW = (FW > NUM_FRAMES_W) ? FW : NUM_FRAMES_W;
    localparam int unsigned SPW = CW + EFW;

    // Sequencer codes.
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CMP  = 2'd1;
    localparam logic [1:0] ST_MUL  = 2'd2;

    logic [1:0]               r_state;
    logic [1:0]               n_state;
    logic [CW-1:0]            r_ptr;
    logic [CW-1:0]            r_hit_ptr;
    logic                     r_frame_done;
    logic [MATCH_CNT_W-1:0]   r_matches;
    logic [MATCH_CNT_W-1:0]   r_cnt_before;
    logic signed [KEY_W-1:0]  r_key;
    logic [PAYLOAD_W-1:0]     r_payload;
    t_out_word                r_result;
    logic                     r_strobe;

    logic [TAG_COUNT_W-1:0]   r_tag_count;
    logic [NUM_FRAMES_W-1:0]  r_num_frames;
    logic [FRAME_INDEX_W-1:0] r_frame_index;
    logic                     r_output_mode;

    logic                     accept;
    logic                     load_we;
    logic                     rec_go;
    logic                     cfg_we;
    logic [CW-1:0]            live;
    logic [CW-1:0]            ptr_inc;
    logic [EFW-1:0]           frames;
    logic [AW-1:0]            ram_raddr;
    logic signed [KEY_W-1:0]  ram_rdata;
    logic                     in_range;
    logic                     tag_below;
    logic                     tag_equal;
    logic                     is_last;
    logic [SPW-1:0]           slot_prod;
    logic [DEST_SLOT_W-1:0]   slot_value;

    // Handshake decode.
    assign busy    = (r_state != ST_IDLE);
    assign accept  = start && !busy;
    assign load_we = accept && (i_item.mode == MODE_LOAD)
                     && (32'(i_item.tag_address) < MAX_TAGS);
    assign rec_go  = accept && (i_item.mode == MODE_RECORD) && !r_frame_done;

    // Effective table size and frame count.
    assign live   = (CW'(r_tag_count) < CW'(MAX_TAGS)) ? CW'(r_tag_count) : CW'(MAX_TAGS);
    assign frames = (EFW'(r_num_frames) < EFW'(MAX_FRAMES))
                    ? EFW'(r_num_frames) : EFW'(MAX_FRAMES);
    assign ptr_inc = r_ptr + 1'b1;

    // Tag table; the scan reads one entry ahead while it steps forward.
    assign ram_raddr = (r_state == ST_CMP) ? ptr_inc[AW-1:0] : r_ptr[AW-1:0];

    stmf_ram #(
        .WIDTH (KEY_W),
        .DEPTH (MAX_TAGS)
    ) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (load_we),
        .i_waddr (AW'(i_item.tag_address)),
        .i_wdata (i_item.key),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Shared compare unit: pointer tag against the held record key.
    assign in_range  = (r_ptr < live);
    assign tag_below = (ram_rdata < r_key);
    assign tag_equal = (ram_rdata == r_key);
    assign is_last   = (ptr_inc >= live);

    // Slot arithmetic for the result stage.
    assign slot_prod  = SPW'(r_hit_ptr) * SPW'(frames);
    assign slot_value = r_output_mode ? DEST_SLOT_W'(r_cnt_before)
                        : DEST_SLOT_W'(slot_prod[DEST_SLOT_W-1:0] + DEST_SLOT_W'(r_frame_index));

    // Next state of the sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (rec_go) begin
                    n_state = ST_CMP;
                end
            end
            ST_CMP: begin
                if (!in_range) begin
                    n_state = ST_IDLE;
                end else if (tag_below) begin
                    if (is_last) begin
                        n_state = ST_IDLE;
                    end
                end else if (tag_equal) begin
                    n_state = ST_MUL;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_MUL: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control state: pointer, frame flags and match count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_ptr        <= '0;
            r_frame_done <= 1'b0;
            r_matches    <= '0;
            r_strobe     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= (r_state == ST_MUL);
            if (accept && (i_item.mode == MODE_START)) begin
                r_ptr        <= '0;
                r_frame_done <= 1'b0;
                r_matches    <= '0;
            end
            if ((r_state == ST_CMP) && in_range) begin
                if (tag_below) begin
                    r_ptr <= ptr_inc;
                end else if (tag_equal) begin
                    r_matches <= r_matches + 1'b1;
                    if (is_last) begin
                        r_frame_done <= 1'b1;
                    end else begin
                        r_ptr <= ptr_inc;
                    end
                end
            end
        end
    end

    // Record data and result fields.
    always_ff @(posedge i_clk) begin
        if (rec_go) begin
            r_key     <= i_item.key;
            r_payload <= i_item.payload;
        end
        if ((r_state == ST_CMP) && in_range && !tag_below && tag_equal) begin
            r_hit_ptr            <= r_ptr;
            r_cnt_before         <= r_matches;
            r_result.tag_index   <= r_ptr[TAG_INDEX_W-1:0];
            r_result.record_out  <= r_payload;
            r_result.match_count <= r_matches + 1'b1;
            r_result.final_tag   <= is_last;
        end
        if (r_state == ST_MUL) begin
            r_result.dest_slot <= slot_value;
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

    // Configuration registers.
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag_count   <= '0;
            r_num_frames  <= NUM_FRAMES_W'(1);
            r_frame_index <= '0;
            r_output_mode <= 1'b0;
        end else if (cfg_we) begin
            unique case (paddr[3:2])
                REG_TAG_COUNT:   r_tag_count   <= pwdata[TAG_COUNT_W-1:0];
                REG_NUM_FRAMES:  r_num_frames  <= pwdata[NUM_FRAMES_W-1:0];
                REG_FRAME_INDEX: r_frame_index <= pwdata[FRAME_INDEX_W-1:0];
                REG_OUTPUT_MODE: r_output_mode <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Register read back.
    always_comb begin
        unique case (paddr[3:2])
            REG_TAG_COUNT:   prdata = 32'(r_tag_count);
            REG_NUM_FRAMES:  prdata = 32'(r_num_frames);
            REG_FRAME_INDEX: prdata = 32'(r_frame_index);
            REG_OUTPUT_MODE: prdata = 32'(r_output_mode);
            default:         prdata = '0;
        endcase
    end

    // A result word always follows the slot multiply cycle.
    `STMF_ASSERT_SAME(a_strobe_after_mul, i_clk, i_rst_n, r_strobe, $past(r_state == ST_MUL))
    // A strobe lasts a single cycle.
    `STMF_ASSERT_NEXT(a_strobe_single, i_clk, i_rst_n, r_strobe, !r_strobe)
    // A closed frame never scans.
    `STMF_ASSERT_SAME(a_no_scan_done, i_clk, i_rst_n, r_state == ST_CMP, !r_frame_done)
    // A final match closes the frame.
    `STMF_ASSERT_SAME(a_final_closes, i_clk, i_rst_n, r_strobe && r_result.final_tag,
        r_frame_done)
    // A record accepted while the frame is open always starts a scan.
    `STMF_ASSERT_NEXT(a_record_scans, i_clk, i_rst_n, rec_go, r_state == ST_CMP)

endmodule
